// ===== hw/rtl/rx_ring_buffer_pool_manager_macros.svh =====
// ----------------------------------------------------------------------------
// rx ring buffer pool manager assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef RX_RING_BUFFER_POOL_MANAGER_MACROS_SVH
`define RX_RING_BUFFER_POOL_MANAGER_MACROS_SVH

// same-cycle implication
`define RRBP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rrbp check failed");

// next-cycle implication
`define RRBP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rrbp check failed");

`endif

// ===== hw/rtl/rrbp_pkg.sv =====
// ----------------------------------------------------------------------------
// rrbp_pkg
// types and constants for the rx ring buffer pool manager
// ----------------------------------------------------------------------------
package rrbp_pkg;

  localparam int FUNC_W   = 2;
  localparam int LEN_W    = 11;
  localparam int STATUS_W = 2;
  localparam int BUFO_W   = 3;
  localparam int SLOTO_W  = 2;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_POLL   = 2'd0,
    FUNC_SEND   = 2'd1,
    FUNC_DONE   = 2'd2,
    FUNC_REINIT = 2'd3
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_TX_BUSY = 2'd2,
    ST_NO_BUF  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOKUP,
    S_EXEC
  } state_t;

  typedef struct packed {
    logic capture;
    logic lookup;
    logic commit;
  } dp_cmd_t;

endpackage

// ===== hw/rtl/rx_ring_buffer_pool_manager.sv =====
// an input transfer is captured, then the slot table is read, then commit fills the result register
// one item is in flight at a time: no new input is taken until its result commits; a held result stalls commit
// this order is set by the sequencer and the registered read port of the slot table
// reset (rst_n low, synchronous) restores the initial pool: slot i holds buffer i,
// the stack holds the spare before last, the transmit descriptor holds none
// slot table entries fall back to their reset mapping through per-slot valid bits
// ----------------------------------------------------------------------------
// rx_ring_buffer_pool_manager
// receive descriptor ring and transmit descriptor over a shared buffer pool
// ----------------------------------------------------------------------------
module rx_ring_buffer_pool_manager
  import rrbp_pkg::*;
#(
  parameter int RX_DESCRIPTORS = 4
)
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [FUNC_W-1:0]   in_func,
  input  logic                in_desc_filled,
  input  logic [LEN_W-1:0]    in_frame_length,
  input  logic [LEN_W-1:0]    in_tx_length,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [STATUS_W-1:0] out_status,
  output logic [LEN_W-1:0]    out_length,
  output logic [BUFO_W-1:0]   out_stack_buffer,
  output logic [BUFO_W-1:0]   out_tx_buffer,
  output logic [SLOTO_W-1:0]  out_slot_served
);

  dp_cmd_t cmd;

  rrbp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  rrbp_datapath #(
    .RX_DESCRIPTORS (RX_DESCRIPTORS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .in_func          (in_func),
    .in_desc_filled   (in_desc_filled),
    .in_frame_length  (in_frame_length),
    .in_tx_length     (in_tx_length),
    .out_status       (out_status),
    .out_length       (out_length),
    .out_stack_buffer (out_stack_buffer),
    .out_tx_buffer    (out_tx_buffer),
    .out_slot_served  (out_slot_served)
  );

endmodule

// ===== hw/rtl/rrbp_ctrl.sv =====
// ----------------------------------------------------------------------------
// rrbp_ctrl
// sequencer: capture, slot table read, commit into the output register
// ----------------------------------------------------------------------------
module rrbp_ctrl
  import rrbp_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  output dp_cmd_t cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   can_commit;

  assign can_commit = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_LOOKUP;
      end
      S_LOOKUP: begin
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (can_commit) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready    = 1'b0;
    cmd.capture = 1'b0;
    cmd.lookup  = 1'b0;
    cmd.commit  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      S_LOOKUP: begin
        cmd.lookup = 1'b1;
      end
      S_EXEC: begin
        cmd.commit = can_commit;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ===== hw/rtl/rrbp_datapath.sv =====
// ----------------------------------------------------------------------------
// rrbp_datapath
// busy map, slot table, ownership registers and result register
// ----------------------------------------------------------------------------
module rrbp_datapath
  import rrbp_pkg::*;
#(
  parameter int RX_DESCRIPTORS = 4
)
(
  input  logic                clk,
  input  logic                rst_n,
  input  dp_cmd_t             cmd,
  input  logic [FUNC_W-1:0]   in_func,
  input  logic                in_desc_filled,
  input  logic [LEN_W-1:0]    in_frame_length,
  input  logic [LEN_W-1:0]    in_tx_length,
  output logic [STATUS_W-1:0] out_status,
  output logic [LEN_W-1:0]    out_length,
  output logic [BUFO_W-1:0]   out_stack_buffer,
  output logic [BUFO_W-1:0]   out_tx_buffer,
  output logic [SLOTO_W-1:0]  out_slot_served
);

  localparam int NB = RX_DESCRIPTORS + 2;
  localparam int BW = $clog2(NB + 1);
  localparam int SW = $clog2(RX_DESCRIPTORS);
  localparam logic [BW-1:0] NONE_BUF  = BW'(NB);
  localparam logic [BW-1:0] STACK_RST = BW'(RX_DESCRIPTORS);
  localparam logic [SW-1:0] LAST_SLOT = SW'(RX_DESCRIPTORS - 1);
  localparam logic [NB-1:0] BUSY_RST  = NB'({(RX_DESCRIPTORS + 1){1'b1}});

  // architectural state
  logic [NB-1:0]             busy_r, busy_nxt;
  logic [SW-1:0]             next_slot_r, next_slot_nxt;
  logic [BW-1:0]             stack_r, stack_nxt;
  logic [BW-1:0]             tx_r, tx_nxt;
  logic                      pending_r, pending_nxt;
  logic [RX_DESCRIPTORS-1:0] slot_vld_r, slot_vld_nxt;

  // slot table
  logic [BW-1:0] slot_mem [RX_DESCRIPTORS];
  logic [BW-1:0] rd_data_r;
  logic          rd_vld_r;
  logic          mem_we;

  // captured item
  func_t            func_r;
  logic             filled_r;
  logic [LEN_W-1:0] flen_r;
  logic [LEN_W-1:0] tlen_r;

  // result register
  status_t           status_r, status_nxt;
  logic [LEN_W-1:0]  length_r, length_nxt;
  logic [SW-1:0]     served_r, served_nxt;

  logic [BW-1:0] slot_buf;
  logic [NB-1:0] busy_poll;
  logic [NB-1:0] busy_send;
  logic [NB-1:0] search_vec;
  logic [NB-1:0] take_vec;
  logic          free_found;
  logic [BW-1:0] free_idx;

  assign slot_buf = rd_vld_r ? rd_data_r : BW'(next_slot_r);

  always_comb begin
    for (int i = 0; i < NB; i++) begin
      busy_poll[i] = busy_r[i] & (stack_r != BW'(i));
      busy_send[i] = busy_r[i] & (tx_r != BW'(i));
    end
  end

  assign search_vec = (func_r == FUNC_POLL) ? busy_poll : busy_send;

  // lowest free buffer
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = NB - 1; i >= 0; i--) begin
      if (!search_vec[i]) begin
        free_found = 1'b1;
        free_idx   = BW'(i);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < NB; i++) begin
      take_vec[i] = search_vec[i] | (free_found && (free_idx == BW'(i)));
    end
  end

  always_comb begin
    busy_nxt      = busy_r;
    next_slot_nxt = next_slot_r;
    stack_nxt     = stack_r;
    tx_nxt        = tx_r;
    pending_nxt   = pending_r;
    slot_vld_nxt  = slot_vld_r;
    mem_we        = 1'b0;
    status_nxt    = ST_OK;
    length_nxt    = '0;
    served_nxt    = next_slot_r;
    unique case (func_r)
      FUNC_POLL: begin
        if (!filled_r) begin
          status_nxt = ST_EMPTY;
        end else if (!free_found) begin
          status_nxt = ST_NO_BUF;
        end else begin
          busy_nxt                  = take_vec;
          stack_nxt                 = slot_buf;
          mem_we                    = 1'b1;
          slot_vld_nxt[next_slot_r] = 1'b1;
          next_slot_nxt = (next_slot_r == LAST_SLOT) ? '0 : next_slot_r + SW'(1);
          length_nxt    = flen_r;
        end
      end
      FUNC_SEND: begin
        if (pending_r) begin
          status_nxt = ST_TX_BUSY;
        end else if (stack_r == NONE_BUF) begin
          status_nxt = ST_NO_BUF;
        end else begin
          busy_nxt    = take_vec;
          tx_nxt      = stack_r;
          pending_nxt = 1'b1;
          length_nxt  = tlen_r;
          stack_nxt   = free_found ? free_idx : NONE_BUF;
          status_nxt  = free_found ? ST_OK : ST_NO_BUF;
        end
      end
      FUNC_DONE: begin
        busy_nxt    = busy_send;
        tx_nxt      = NONE_BUF;
        pending_nxt = 1'b0;
      end
      FUNC_REINIT: begin
        busy_nxt      = BUSY_RST;
        next_slot_nxt = '0;
        stack_nxt     = STACK_RST;
        tx_nxt        = NONE_BUF;
        pending_nxt   = 1'b0;
        slot_vld_nxt  = '0;
        served_nxt    = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= BUSY_RST;
      next_slot_r <= '0;
      stack_r     <= STACK_RST;
      tx_r        <= NONE_BUF;
      pending_r   <= 1'b0;
      slot_vld_r  <= '0;
    end else if (cmd.commit) begin
      busy_r      <= busy_nxt;
      next_slot_r <= next_slot_nxt;
      stack_r     <= stack_nxt;
      tx_r        <= tx_nxt;
      pending_r   <= pending_nxt;
      slot_vld_r  <= slot_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && mem_we) begin
      slot_mem[next_slot_r] <= free_idx;
    end
    if (cmd.lookup) begin
      rd_data_r <= slot_mem[next_slot_r];
      rd_vld_r  <= slot_vld_r[next_slot_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      func_r <= FUNC_POLL;
    end else if (cmd.capture) begin
      func_r <= func_t'(in_func);
    end
    if (cmd.capture) begin
      filled_r <= in_desc_filled;
      flen_r   <= in_frame_length;
      tlen_r   <= in_tx_length;
    end
    if (cmd.commit) begin
      status_r <= status_nxt;
      length_r <= length_nxt;
      served_r <= served_nxt;
    end
  end

  // ownership outputs follow the committed state
  assign out_status       = status_r;
  assign out_length       = length_r;
  assign out_stack_buffer = BUFO_W'(stack_r);
  assign out_tx_buffer    = BUFO_W'(tx_r);
  assign out_slot_served  = SLOTO_W'(served_r);

endmodule

// ===== hw/rtl/rrbp_checker.sv =====
// ----------------------------------------------------------------------------
// rrbp_checker
// port-level checks for the rx ring buffer pool manager
// ----------------------------------------------------------------------------
`include "rx_ring_buffer_pool_manager_macros.svh"

module rrbp_checker
  import rrbp_pkg::*;
(
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic [STATUS_W-1:0] out_status,
  input logic [LEN_W-1:0]    out_length,
  input logic [BUFO_W-1:0]   out_stack_buffer,
  input logic [BUFO_W-1:0]   out_tx_buffer,
  input logic [SLOTO_W-1:0]  out_slot_served
);

  // a held result keeps its payload
  `RRBP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_status) && $stable(out_length) && $stable(out_stack_buffer) && $stable(out_tx_buffer) && $stable(out_slot_served))

  // one item in flight: no transfer in the cycle after one
  `RRBP_ASSERT_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready)

  // a result never appears in the cycle right after an input transfer
  `RRBP_ASSERT_NEXT(a_min_latency, in_valid && in_ready && !out_valid, !out_valid)

  // empty slot and busy transmitter carry no length
  `RRBP_ASSERT_NOW(a_reject_len, out_valid && (out_status == ST_EMPTY || out_status == ST_TX_BUSY), out_length == '0)

endmodule

bind rx_ring_buffer_pool_manager rrbp_checker u_rrbp_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_status       (out_status),
  .out_length       (out_length),
  .out_stack_buffer (out_stack_buffer),
  .out_tx_buffer    (out_tx_buffer),
  .out_slot_served  (out_slot_served)
);

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// checks the rx ring buffer pool manager against an in-bench model of the
// buffer pool: directed events first, then bursts of random events with
// random input gaps and output stalls, every result compared in order
// ----------------------------------------------------------------------------
module tb;
  import rrbp_pkg::*;

  localparam int RING_SLOTS     = 4;
  localparam int NUM_BUFFERS    = RING_SLOTS + 2;
  localparam int NO_BUFFER      = RING_SLOTS + 2;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_ITEMS   = 1250;
  localparam int PHASE_ITEMS    = 250;

  typedef struct packed {
    status_t            status;
    logic [LEN_W-1:0]   length;
    logic [BUFO_W-1:0]  stack_buf;
    logic [BUFO_W-1:0]  tx_buf;
    logic [SLOTO_W-1:0] slot;
  } pool_result_t;

  class pool_scoreboard;
    bit           busy [NUM_BUFFERS];
    int unsigned  slot_buf [RING_SLOTS];
    int unsigned  ring_pos;
    int unsigned  stack_buf;
    int unsigned  tx_buf;
    bit           tx_queued;
    pool_result_t expected_q [$];
    int unsigned  mismatches;
    int unsigned  func_seen [4];
    int unsigned  status_seen [4];

    function new();
      restore_pool();
    endfunction

    function void restore_pool();
      for (int i = 0; i < NUM_BUFFERS; i++) busy[i] = (i <= RING_SLOTS);
      for (int i = 0; i < RING_SLOTS; i++) slot_buf[i] = i;
      ring_pos  = 0;
      stack_buf = RING_SLOTS;
      tx_buf    = NO_BUFFER;
      tx_queued = 1'b0;
    endfunction

    function void free_buf(int unsigned b);
      if (b < NUM_BUFFERS) busy[b] = 1'b0;
    endfunction

    function int unsigned grab_lowest_free();
      for (int i = 0; i < NUM_BUFFERS; i++) begin
        if (!busy[i]) begin
          busy[i] = 1'b1;
          return i;
        end
      end
      return NO_BUFFER;
    endfunction

    function void note_input(func_t f, bit filled, logic [LEN_W-1:0] flen,
                             logic [LEN_W-1:0] tlen);
      pool_result_t r;
      int unsigned  slot;
      int unsigned  nb;
      bit           was_busy;
      slot     = ring_pos;
      r.status = ST_OK;
      r.length = '0;
      r.slot   = SLOTO_W'(slot);
      case (f)
        FUNC_POLL: begin
          if (!filled) begin
            r.status = ST_EMPTY;
          end else begin
            was_busy = (stack_buf < NUM_BUFFERS) ? busy[stack_buf] : 1'b0;
            free_buf(stack_buf);
            nb = grab_lowest_free();
            if (nb == NO_BUFFER) begin
              if (stack_buf < NUM_BUFFERS) busy[stack_buf] = was_busy;
              r.status = ST_NO_BUF;
            end else begin
              stack_buf      = slot_buf[slot];
              slot_buf[slot] = nb;
              ring_pos       = (slot + 1 >= RING_SLOTS) ? 0 : slot + 1;
              r.length       = flen;
            end
          end
        end
        FUNC_SEND: begin
          if (tx_queued) begin
            r.status = ST_TX_BUSY;
          end else if (stack_buf >= NUM_BUFFERS) begin
            r.status = ST_NO_BUF;
          end else begin
            free_buf(tx_buf);
            tx_buf    = stack_buf;
            tx_queued = 1'b1;
            r.length  = tlen;
            stack_buf = grab_lowest_free();
            if (stack_buf == NO_BUFFER) r.status = ST_NO_BUF;
          end
        end
        FUNC_DONE: begin
          free_buf(tx_buf);
          tx_buf    = NO_BUFFER;
          tx_queued = 1'b0;
        end
        FUNC_REINIT: begin
          restore_pool();
        end
      endcase
      if (f != FUNC_POLL) r.slot = SLOTO_W'(ring_pos);
      r.stack_buf = BUFO_W'(stack_buf);
      r.tx_buf    = BUFO_W'(tx_buf);
      expected_q.push_back(r);
      func_seen[f]++;
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $error("%s mismatch: expected %0d, actual %0d", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(logic [STATUS_W-1:0] status, logic [LEN_W-1:0] length,
                               logic [BUFO_W-1:0] stack_b, logic [BUFO_W-1:0] tx_b,
                               logic [SLOTO_W-1:0] slot);
      pool_result_t want;
      if (expected_q.size() == 0) begin
        $error("result transfer with nothing expected: status %0d length %0d",
               status, length);
        mismatches++;
        return;
      end
      want = expected_q.pop_front();
      compare_field("status", 16'(want.status), 16'(status));
      compare_field("length", 16'(want.length), 16'(length));
      compare_field("stack_buffer", 16'(want.stack_buf), 16'(stack_b));
      compare_field("tx_buffer", 16'(want.tx_buf), 16'(tx_b));
      compare_field("slot_served", 16'(want.slot), 16'(slot));
      status_seen[want.status]++;
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [FUNC_W-1:0]   in_func = FUNC_POLL;
  logic                in_desc_filled = 1'b0;
  logic [LEN_W-1:0]    in_frame_length = '0;
  logic [LEN_W-1:0]    in_tx_length = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [STATUS_W-1:0] out_status;
  logic [LEN_W-1:0]    out_length;
  logic [BUFO_W-1:0]   out_stack_buffer;
  logic [BUFO_W-1:0]   out_tx_buffer;
  logic [SLOTO_W-1:0]  out_slot_served;

  pool_scoreboard sb = new();
  int unsigned    idle_cycles = 0;
  int unsigned    stall_left = 0;
  int unsigned    stall_pct = 0;
  int unsigned    stall_max = 0;

  rx_ring_buffer_pool_manager #(
    .RX_DESCRIPTORS(RING_SLOTS)
  ) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_func         (in_func),
    .in_desc_filled  (in_desc_filled),
    .in_frame_length (in_frame_length),
    .in_tx_length    (in_tx_length),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_length      (out_length),
    .out_stack_buffer(out_stack_buffer),
    .out_tx_buffer   (out_tx_buffer),
    .out_slot_served (out_slot_served)
  );

  always #1 clk = ~clk;

  // receiver stall pattern
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if ($urandom_range(0, 99) < stall_pct) begin
      stall_left <= $urandom_range(0, stall_max);
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // transfer monitor and watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready)
        sb.note_input(func_t'(in_func), in_desc_filled, in_frame_length, in_tx_length);
      if (out_valid && out_ready)
        sb.check_result(out_status, out_length, out_stack_buffer, out_tx_buffer,
                        out_slot_served);
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", idle_cycles);
        $display("status: fail");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  task automatic send_item(func_t f, bit filled, logic [LEN_W-1:0] flen,
                           logic [LEN_W-1:0] tlen);
    in_valid        <= 1'b1;
    in_func         <= f;
    in_desc_filled  <= filled;
    in_frame_length <= flen;
    in_tx_length    <= tlen;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic idle_gap(int unsigned n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
  endtask

  function automatic logic [LEN_W-1:0] random_length();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return LEN_W'($urandom_range(0, (1 << LEN_W) - 1));
    endcase
  endfunction

  initial begin
    int unsigned sent;
    int unsigned burst;
    int unsigned pick;
    int unsigned mode;
    func_t       f;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed events
    send_item(FUNC_POLL,   1'b0, 11'h7ff, 11'h000);
    send_item(FUNC_DONE,   1'b1, 11'h000, 11'h7ff);
    send_item(FUNC_POLL,   1'b1, 11'h000, 11'h000);
    send_item(FUNC_POLL,   1'b1, 11'h7ff, 11'h7ff);
    send_item(FUNC_SEND,   1'b0, 11'h000, 11'h7ff);
    send_item(FUNC_SEND,   1'b1, 11'h7ff, 11'h001);
    send_item(FUNC_POLL,   1'b1, 11'h001, 11'h000);
    send_item(FUNC_POLL,   1'b1, 11'h400, 11'h000);
    send_item(FUNC_POLL,   1'b1, 11'h2aa, 11'h555);
    send_item(FUNC_POLL,   1'b0, 11'h555, 11'h2aa);
    send_item(FUNC_DONE,   1'b0, 11'h000, 11'h000);
    send_item(FUNC_DONE,   1'b0, 11'h000, 11'h000);
    send_item(FUNC_SEND,   1'b1, 11'h7ff, 11'h000);
    send_item(FUNC_POLL,   1'b1, 11'h3ff, 11'h7ff);
    send_item(FUNC_REINIT, 1'b1, 11'h7ff, 11'h7ff);
    send_item(FUNC_POLL,   1'b0, 11'h000, 11'h000);
    send_item(FUNC_SEND,   1'b0, 11'h000, 11'h555);
    send_item(FUNC_REINIT, 1'b0, 11'h000, 11'h000);
    send_item(FUNC_SEND,   1'b1, 11'h000, 11'h2aa);
    send_item(FUNC_DONE,   1'b1, 11'h7ff, 11'h7ff);
    send_item(FUNC_POLL,   1'b1, 11'h7ff, 11'h000);
    send_item(FUNC_SEND,   1'b0, 11'h000, 11'h7fe);
    send_item(FUNC_DONE,   1'b0, 11'h000, 11'h000);
    wait_drained();

    // random events in phases with different idling on both sides
    sent = 0;
    for (int phase = 0; sent < RANDOM_ITEMS; phase++) begin
      mode = phase % 5;
      stall_pct <= (mode == 2 || mode == 3) ? 30 : (mode == 4) ? 55 : 0;
      stall_max <= (mode == 4) ? 15 : 6;
      for (int n = 0; n < PHASE_ITEMS && sent < RANDOM_ITEMS; ) begin
        burst = $urandom_range(1, 16);
        for (int b = 0; b < burst; b++) begin
          pick = $urandom_range(0, 99);
          if (pick < 50)      f = FUNC_POLL;
          else if (pick < 72) f = FUNC_SEND;
          else if (pick < 94) f = FUNC_DONE;
          else                f = FUNC_REINIT;
          send_item(f, ($urandom_range(0, 4) != 0), random_length(), random_length());
          sent++;
          n++;
        end
        if ((mode == 1 || mode == 3 || mode == 4) && $urandom_range(0, 3) != 0)
          idle_gap($urandom_range(1, 8));
      end
      wait_drained();
    end

    repeat (8) @(posedge clk);
    $display("events: %0d polls, %0d sends, %0d transmit done, %0d reinitialise",
             sb.func_seen[FUNC_POLL], sb.func_seen[FUNC_SEND],
             sb.func_seen[FUNC_DONE], sb.func_seen[FUNC_REINIT]);
    $display("results: %0d ok, %0d empty slot, %0d transmitter busy, %0d no buffer",
             sb.status_seen[ST_OK], sb.status_seen[ST_EMPTY],
             sb.status_seen[ST_TX_BUSY], sb.status_seen[ST_NO_BUF]);
    if (sb.mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
